/* design/time_triggered_task_table_core_macros.svh */
// ---------------------------------------------------------------------------
// time_triggered_task_table_core_macros
// assertion macros used by the task table core
// ---------------------------------------------------------------------------
`ifndef TIME_TRIGGERED_TASK_TABLE_CORE_MACROS_SVH
`define TIME_TRIGGERED_TASK_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/ttt_pkg.sv */
// ---------------------------------------------------------------------------
// ttt_pkg
// commands, status codes and sequencer states of the task table
// ---------------------------------------------------------------------------
package ttt_pkg;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_ADD      = 3'd1,
      CMD_DELETE   = 3'd2,
      CMD_DISPATCH = 3'd3,
      CMD_EDIT     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_BAD  = 2'd2,
      STAT_IDLE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // most results one dispatch may give
   localparam int unsigned MAX_OUT  = 16;
   localparam int unsigned SERVED_W = 5;
   localparam logic [7:0]  PEND_MAX = 8'd255;

endpackage

/* design/time_triggered_task_table_core.sv */
// ---------------------------------------------------------------------------
// time_triggered_task_table_core
// table of periodic and one-shot task slots held in a rotating ring of cells
// ---------------------------------------------------------------------------
// usage
//   req_* carries one command per transfer: tick, add, delete, dispatch or
//   edit period. rsp_* returns the results; rsp_last marks the final one
//   of a command. a dispatch gives one result per due slot, up to MAX_OUT,
//   in index order (one idle result if none is due); every other command
//   gives exactly one result.
// timing
//   the slots sit in a ring of TASK_COUNT cells. after a command is taken
//   the ring turns once, one slot per cycle unless the ring pauses,
//   passing the head cell where the command is applied. the final result
//   is presented once the ring has turned and the output register is free;
//   one command is in work at a time and req_ready is high only between
//   commands.
// reset
//   reset clears every slot, the sequencer and the output valid flag.
// stalls
//   results wait in the output register until taken. a dispatch keeps one
//   found slot aside to learn whether it is the last; if a second due slot
//   arrives while the output register is still full the ring pauses.
// ---------------------------------------------------------------------------
module time_triggered_task_table_core
   import ttt_pkg::*;
#(
   parameter int unsigned TASK_COUNT = 16,
   parameter int unsigned TIME_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_slot,
   input  logic [7:0]  req_task_tag,
   input  logic [15:0] req_first_delay,
   input  logic [15:0] req_run_period,
   input  logic        req_overdue_allow,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot_out,
   output logic [7:0]  rsp_tag_out,
   output logic        rsp_last
);

`include "time_triggered_task_table_core_macros.svh"

   localparam int unsigned IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

   typedef struct packed {
      logic                 valid;
      logic [7:0]           tag;
      logic [TIME_BITS-1:0] delay;
      logic [TIME_BITS-1:0] period;
      logic [7:0]           pending;
      logic                 overdue;
   } slot_type;

   localparam int unsigned SLOT_W = $bits(slot_type);

   // sequencer and command registers
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   cmd_type              cmd_ff;
   logic [7:0]           slot_ff;
   logic [7:0]           tag_ff;
   logic [15:0]          first_delay_ff;
   logic [15:0]          run_period_ff;
   logic                 overdue_ff;

   // per-command scan results
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     found_idx_ff, found_idx_in;
   logic                 hit_ff, hit_in;
   logic [SERVED_W-1:0]  served_ff, served_in;

   // dispatch slot kept aside until the next one is known
   logic                 hold_valid_ff, hold_valid_in;
   logic [3:0]           hold_slot_ff, hold_slot_in;
   logic [7:0]           hold_tag_ff, hold_tag_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_slot_ff, rsp_slot_in;
   logic [7:0]           rsp_tag_ff, rsp_tag_in;
   logic                 rsp_last_ff, rsp_last_in;

   // ring
   logic [SLOT_W-1:0]    ring_q [TASK_COUNT];
   slot_type             head;
   slot_type             head_upd;
   logic                 step;
   logic                 due;
   logic                 take;
   logic                 hit;
   logic                 stall;
   logic                 out_free;
   logic                 req_xfer;
   logic                 idx_match;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ring of cells: cell i takes cell i+1, the last cell takes the updated head
   for (genvar gi = 0; gi < TASK_COUNT; gi++) begin : g_cell
      logic [SLOT_W-1:0] cell_in;
      if (gi == TASK_COUNT - 1) begin : g_tail
         assign cell_in = head_upd;
      end else begin : g_body
         assign cell_in = ring_q[gi+1];
      end
      ttt_cell #(
         .SLOT_W (SLOT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (step),
         .slot_in  (cell_in),
         .slot_out (ring_q[gi])
      );
   end

   // head cell holds slot number cnt_ff while the ring turns
   assign head      = slot_type'(ring_q[0]);
   assign idx_match = (slot_ff == 8'(cnt_ff));

   // command applied to the slot at the head
   always_comb begin
      head_upd = head;
      due      = 1'b0;
      take     = 1'b0;
      hit      = 1'b0;
      unique case (cmd_ff)
         CMD_TICK: begin
            if (head.valid) begin
               if (head.delay == '0) begin
                  if (head.pending != PEND_MAX) begin
                     head_upd.pending = head.pending + 8'd1;
                  end
                  // without overdue runs the count never goes above one
                  if (!head.overdue && (head_upd.pending > 8'd1)) begin
                     head_upd.pending = 8'd1;
                  end
                  if (head.period != '0) begin
                     head_upd.delay = head.period - TIME_BITS'(1);
                  end
               end else begin
                  head_upd.delay = head.delay - TIME_BITS'(1);
               end
            end
         end
         CMD_ADD: begin
            // first free slot only
            if (!head.valid && !found_ff) begin
               take             = 1'b1;
               head_upd.valid   = 1'b1;
               head_upd.tag     = tag_ff;
               head_upd.delay   = TIME_BITS'(first_delay_ff);
               head_upd.period  = TIME_BITS'(run_period_ff);
               head_upd.pending = 8'd0;
               head_upd.overdue = overdue_ff;
            end
         end
         CMD_DELETE: begin
            if (head.valid && idx_match) begin
               hit      = 1'b1;
               head_upd = '0;
            end
         end
         CMD_DISPATCH: begin
            if (head.valid && (head.pending != 8'd0) && (served_ff < SERVED_W'(MAX_OUT))) begin
               due              = 1'b1;
               head_upd.pending = head.pending - 8'd1;
               // one-shot task leaves the table once run
               if (head.period == '0) begin
                  head_upd = '0;
               end
            end
         end
         CMD_EDIT: begin
            if (head.valid && idx_match) begin
               hit             = 1'b1;
               head_upd.period = TIME_BITS'(run_period_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // a second due slot needs the kept one moved out first
   assign stall = due && hold_valid_ff && !out_free;
   assign step  = (state_ff == S_SCAN) && !stall;

   // sequencer, scan bookkeeping and output register
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      hit_in        = hit_ff;
      served_in     = served_ff;
      hold_valid_in = hold_valid_ff;
      hold_slot_in  = hold_slot_ff;
      hold_tag_in   = hold_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in      = S_SCAN;
               cnt_in        = '0;
               found_in      = 1'b0;
               found_idx_in  = '0;
               hit_in        = 1'b0;
               served_in     = '0;
               hold_valid_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (step) begin
               if (take) begin
                  found_in     = 1'b1;
                  found_idx_in = cnt_ff;
               end
               if (hit) begin
                  hit_in = 1'b1;
               end
               if (due) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_OK;
                     rsp_slot_in   = hold_slot_ff;
                     rsp_tag_in    = hold_tag_ff;
                     rsp_last_in   = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_slot_in  = 4'(cnt_ff);
                  hold_tag_in   = head.tag;
                  served_in     = served_ff + SERVED_W'(1);
               end
               if (cnt_ff == IDX_W'(TASK_COUNT - 1)) begin
                  state_in = S_DONE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in      = S_IDLE;
               hold_valid_in = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = 4'd0;
               rsp_tag_in    = 8'd0;
               rsp_last_in   = 1'b1;
               unique case (cmd_ff)
                  CMD_TICK: begin
                     rsp_status_in = STAT_OK;
                  end
                  CMD_ADD: begin
                     if (found_ff) begin
                        rsp_status_in = STAT_OK;
                        rsp_slot_in   = 4'(found_idx_ff);
                     end else begin
                        rsp_status_in = STAT_FULL;
                     end
                  end
                  CMD_DELETE, CMD_EDIT: begin
                     rsp_status_in = hit_ff ? STAT_OK : STAT_BAD;
                  end
                  CMD_DISPATCH: begin
                     if (hold_valid_ff) begin
                        rsp_status_in = STAT_OK;
                        rsp_slot_in   = hold_slot_ff;
                        rsp_tag_in    = hold_tag_ff;
                     end else begin
                        rsp_status_in = STAT_IDLE;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_BAD;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         found_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         served_ff     <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         found_ff      <= found_in;
         hit_ff        <= hit_in;
         served_ff     <= served_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff         <= cmd_type'(req_cmd);
         slot_ff        <= req_slot;
         tag_ff         <= req_task_tag;
         first_delay_ff <= req_first_delay;
         run_period_ff  <= req_run_period;
         overdue_ff     <= req_overdue_allow;
      end
      found_idx_ff  <= found_idx_in;
      hold_slot_ff  <= hold_slot_in;
      hold_tag_ff   <= hold_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_tag_out  = rsp_tag_ff;
   assign rsp_last     = rsp_last_ff;

   // checks
   `TTT_ASSERT_NOW(a_served_bound, clock, reset, 1'b1, served_ff <= SERVED_W'(MAX_OUT), "dispatch served more than the result limit")
   `TTT_ASSERT_NOW(a_hold_only_dispatch, clock, reset, hold_valid_ff, (cmd_ff == CMD_DISPATCH) && (state_ff != S_IDLE), "kept slot outside a dispatch")
   `TTT_ASSERT_NEXT(a_final_result, clock, reset, (state_ff == S_DONE) && out_free, rsp_valid_ff && rsp_last_ff && (state_ff == S_IDLE), "final result not presented")

endmodule

/* design/ttt_cell.sv */
// ---------------------------------------------------------------------------
// ttt_cell
// one slot holder of the rotating ring, takes its neighbour's slot on shift
// ---------------------------------------------------------------------------
module ttt_cell
   import ttt_pkg::*;
#(
   parameter int unsigned SLOT_W = 50
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic [SLOT_W-1:0] slot_in,
   output logic [SLOT_W-1:0] slot_out
);

   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in_mux;

   assign slot_in_mux = shift_en ? slot_in : slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in_mux;
      end
   end

   assign slot_out = slot_ff;

endmodule
